>>> hw/rtl/spq_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// spq_pkg
// shared types, codes and sizes of the sorted priority queue
// ----------------------------------------------------------------------------
package spq_pkg;

  localparam int QUEUE_DEPTH = 16;
  localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);
  localparam int PRIO_W      = 16;
  localparam int DATA_W      = 32;
  localparam int STATUS_W    = 2;
  localparam int FILL_W      = 5;

  typedef enum logic {
    FUNC_INSERT = 1'b0,
    FUNC_REMOVE = 1'b1
  } func_t;

  typedef enum logic [STATUS_W-1:0] {
    STATUS_DONE      = 2'd0,
    STATUS_UNDERFLOW = 2'd1,
    STATUS_FULL      = 2'd2
  } status_t;

  typedef struct packed {
    logic [PRIO_W-1:0] prio;
    logic [DATA_W-1:0] data;
  } entry_t;

  // broadcast from the top level to every cell
  typedef struct packed {
    logic   ins;
    logic   rem;
    entry_t item;
  } cell_ctl_t;

endpackage : spq_pkg
`default_nettype wire

>>> hw/rtl/spq_req_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// spq_req_if
// request channel: insert or remove operation beats
// ----------------------------------------------------------------------------
interface spq_req_if;
  logic                      valid;
  logic                      ready;
  logic                      func;
  logic [spq_pkg::PRIO_W-1:0] item_priority;
  logic [spq_pkg::DATA_W-1:0] item_data;

  modport source (output valid, func, item_priority, item_data, input ready);
  modport sink   (input valid, func, item_priority, item_data, output ready);
endinterface : spq_req_if
`default_nettype wire

>>> hw/rtl/spq_rsp_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// spq_rsp_if
// response channel: one beat per request
// ----------------------------------------------------------------------------
interface spq_rsp_if;
  logic                        valid;
  logic                        ready;
  logic [spq_pkg::DATA_W-1:0]   out_data;
  logic [spq_pkg::PRIO_W-1:0]   out_priority;
  logic [spq_pkg::STATUS_W-1:0] status;
  logic [spq_pkg::FILL_W-1:0]   fill_level;

  modport source (output valid, out_data, out_priority, status, fill_level, input ready);
  modport sink   (input valid, out_data, out_priority, status, fill_level, output ready);
endinterface : spq_rsp_if
`default_nettype wire

>>> hw/rtl/spq_cell.sv
`default_nettype none
// ----------------------------------------------------------------------------
// spq_cell
// one slot of the sorted chain: keeps, takes the new item, or shifts
// ----------------------------------------------------------------------------
module spq_cell (
  input  wire logic               clk,
  input  wire spq_pkg::cell_ctl_t ctl,
  input  wire logic               occupied,
  input  wire logic               left_le,
  input  wire spq_pkg::entry_t    left_entry,
  input  wire spq_pkg::entry_t    right_entry,
  output spq_pkg::entry_t         entry,
  output logic                    le
);
  import spq_pkg::*;

  // stored and served no later than the new item
  assign le = occupied && (entry.prio <= ctl.item.prio);

  always_ff @(posedge clk) begin
    if (ctl.ins) begin
      if (!le) begin
        if (left_le) begin
          entry <= ctl.item;
        end else begin
          entry <= left_entry;
        end
      end
    end else if (ctl.rem) begin
      entry <= right_entry;
    end
  end

endmodule : spq_cell
`default_nettype wire

>>> hw/rtl/sorted_priority_queue_top.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sorted_priority_queue_top
// bounded priority queue kept sorted in a chain of shifting cells
// ----------------------------------------------------------------------------
// response: the response beat of a request is registered and valid in the cycle after it
// throughput: one beat per cycle unless rsp.ready holds it; every cell settles from
//   its own compare and its neighbors, so the chain takes a new beat each cycle
// reset: clears the fill count and the response valid; cell contents are
//   left as they are and only slots below the count are ever read
// ----------------------------------------------------------------------------
module sorted_priority_queue_top (
  input  wire logic clk,
  input  wire logic rst,
  spq_req_if.sink   req,
  spq_rsp_if.source rsp
);
  import spq_pkg::*;

  // fill count, the only occupancy state
  logic [CNT_W-1:0] count;
  logic [CNT_W-1:0] count_next;

  // chain of cells, slot 0 served first
  entry_t                 entries [QUEUE_DEPTH];
  logic [QUEUE_DEPTH-1:0] le;
  cell_ctl_t              ctl;

  logic req_beat;
  logic is_remove;
  logic full;
  logic empty;

  // response register parts the two sides: a new beat is taken as soon as
  // the waiting response leaves or in the same cycle
  assign req.ready = !rsp.valid || rsp.ready;
  assign req_beat  = req.valid && req.ready;

  assign is_remove = (req.func == FUNC_REMOVE);
  assign full      = (count == CNT_W'(QUEUE_DEPTH));
  assign empty     = (count == '0);

  // broadcast to all cells: new item and the move of this cycle
  always_comb begin
    ctl.ins       = req_beat && !is_remove && !full;
    ctl.rem       = req_beat && is_remove && !empty;
    ctl.item.prio = req.item_priority;
    ctl.item.data = req.item_data;
  end

  always_comb begin
    count_next = count;
    if (ctl.ins) begin
      count_next = count + 1'b1;
    end else if (ctl.rem) begin
      count_next = count - 1'b1;
    end
  end

  for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
    logic   occ;
    logic   left_le;
    entry_t left_entry;
    entry_t right_entry;

    assign occ = (CNT_W'(i) < count);

    // the head has nothing ahead of it, so a non-kept head takes the new item
    if (i == 0) begin : g_head
      assign left_le    = 1'b1;
      assign left_entry = ctl.item;
    end else begin : g_body
      assign left_le    = le[i-1];
      assign left_entry = entries[i-1];
    end

    // the tail slot keeps its own content on a remove (it falls out of range)
    if (i == QUEUE_DEPTH - 1) begin : g_tail
      assign right_entry = entries[i];
    end else begin : g_mid
      assign right_entry = entries[i+1];
    end

    spq_cell u_cell (
      .clk        (clk),
      .ctl        (ctl),
      .occupied   (occ),
      .left_le    (left_le),
      .left_entry (left_entry),
      .right_entry(right_entry),
      .entry      (entries[i]),
      .le         (le[i])
    );
  end

  // count and response register
  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      rsp.valid <= 1'b0;
    end else begin
      count <= count_next;
      if (req_beat) begin
        rsp.valid <= 1'b1;
      end else if (rsp.ready) begin
        rsp.valid <= 1'b0;
      end
    end
    if (req_beat) begin
      rsp.fill_level   <= FILL_W'(count_next);
      rsp.out_data     <= ctl.rem ? entries[0].data : '0;
      rsp.out_priority <= ctl.rem ? entries[0].prio : '0;
      if (is_remove && empty) begin
        rsp.status <= STATUS_UNDERFLOW;
      end else if (!is_remove && full) begin
        rsp.status <= STATUS_FULL;
      end else begin
        rsp.status <= STATUS_DONE;
      end
    end
  end

  // checks

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(QUEUE_DEPTH))
    else $error("fill count above queue depth");

  a_full_drop: assert property (@(posedge clk) disable iff (rst)
    (req_beat && !is_remove && full) |=> (count == $past(count)))
    else $error("insert into full queue changed the count");

  a_remove_dec: assert property (@(posedge clk) disable iff (rst)
    ctl.rem |=> (count == $past(count) - 1'b1))
    else $error("remove did not lower the count");

  a_head_sorted: assert property (@(posedge clk) disable iff (rst)
    (count >= CNT_W'(2)) |-> (entries[0].prio <= entries[1].prio))
    else $error("head pair out of order");

endmodule : sorted_priority_queue_top
`default_nettype wire
